// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the RTL that checks itself.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define PCRMV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define PCRMV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/pcrmv_pkg.sv -----
// Types and constants of the per-channel running mean/variance block.
// No dependencies.
package pcrmv_pkg;

    localparam int CHANNELS_DEF    = 4096;
    localparam int MAX_SPECTRA_DEF = 65535;

    localparam int SAMPLE_BITS   = 8;
    localparam int FRACTION_BITS = 16;
    localparam int MEAN_W        = SAMPLE_BITS + FRACTION_BITS;
    localparam int SUM_W         = 2 * SAMPLE_BITS + 16 + FRACTION_BITS;
    localparam int SUM_HALF      = SUM_W / 2;
    localparam int RECIP_W       = 32;
    localparam int VAR_W         = 30;
    localparam int IDX_W         = 12;
    localparam int COUNT_W       = 16;
    localparam int CH_FIELD_W    = 16;
    localparam int CFG_W         = 13;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;
    localparam int QUEUE_DEPTH   = 2;
    localparam int OUT_DATA_W    = 88;

    localparam logic [MEAN_W-1:0] MEAN_MAX =
        MEAN_W'(((64'd1 << SAMPLE_BITS) - 64'd1) << FRACTION_BITS);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [CH_FIELD_W-1:0]  ch;
        logic [COUNT_W-1:0]     n;
        logic                   recalc;
        logic                   stopped;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [MEAN_W-1:0]  mean;
        logic [VAR_W-1:0]   variance;
        logic [COUNT_W-1:0] count;
        logic               sat;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_STEP,
        ST_MEAN,
        ST_DEV,
        ST_UPD,
        ST_VLO,
        ST_VHI,
        ST_OUT
    } t_bstate;

endpackage

// ----- hw/rtl/pcrmv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcrmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/pcrmv_front.sv -----
// Front end: takes sample words, tracks channel and spectrum, issues commands.
// Depends on pcrmv_pkg.
module pcrmv_front import pcrmv_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int MAX_SPECTRA = MAX_SPECTRA_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_start,
    input  t_qstat                 i_qstat,
    output logic                   o_ready,
    output logic                   o_push,
    output t_cmd                   o_cmd
);
    localparam int PW = $clog2(CHANNELS + 1);

    logic [CFG_W-1:0]   r_cfg;
    logic [PW-1:0]      r_pos, n_pos;
    logic [COUNT_W-1:0] r_seen, n_seen;
    logic               r_stop, n_stop;
    logic [PW-1:0]      limit;
    logic [PW-1:0]      pos1;

    always_comb begin
        logic [PW-1:0]      pos0;
        logic [PW:0]        pos_inc;
        logic [COUNT_W-1:0] seen0;
        logic               stop0;
        logic               recalc;
        pos0 = i_start ? '0 : r_pos;
        seen0 = i_start ? '0 : r_seen;
        stop0 = i_start ? 1'b0 : r_stop;
        recalc = 1'b0;
        n_seen = seen0;
        n_stop = stop0;

        if (r_cfg == '0) begin
            limit = PW'(1);
        end else if (32'(r_cfg) > CHANNELS) begin
            limit = PW'(CHANNELS);
        end else begin
            limit = PW'(r_cfg);
        end

        pos1 = (pos0 >= limit) ? '0 : pos0;
        if (pos1 == '0) begin
            if (32'(seen0) < MAX_SPECTRA) begin
                n_seen = seen0 + 1'b1;
                recalc = 1'b1;
            end else begin
                n_stop = 1'b1;
            end
        end
        pos_inc = {1'b0, pos1} + 1'b1;
        n_pos = (pos_inc >= {1'b0, limit}) ? '0 : pos_inc[PW-1:0];

        o_cmd.sample = i_sample;
        o_cmd.ch = CH_FIELD_W'(pos1);
        o_cmd.n = n_seen;
        o_cmd.recalc = recalc;
        o_cmd.stopped = n_stop;
    end

    assign o_ready = !i_qstat.full;
    assign o_push = i_valid && !i_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
            r_pos <= '0;
            r_seen <= '0;
            r_stop <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (o_push) begin
                r_pos <= n_pos;
                r_seen <= n_seen;
                r_stop <= n_stop;
            end
        end
    end
endmodule

// ----- hw/rtl/pcrmv_queue.sv -----
// Two-entry command queue between front and back ends.
// Depends on pcrmv_pkg.
module pcrmv_queue import pcrmv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_cmd,
    output t_qstat o_qstat
);
    localparam int QA = $clog2(QUEUE_DEPTH);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [QA-1:0] r_wp, r_rp;
    logic [QA:0]   r_cnt;

    assign o_cmd = r_slot[r_rp];
    assign o_qstat.full = (r_cnt == (QA+1)'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QA+1)'(i_push) - (QA+1)'(i_pop);
        end
    end
endmodule

// ----- hw/rtl/pcrmv_back.sv -----
// Back end: reciprocal divider, Welford update over channel RAMs, output register.
// Depends on pcrmv_pkg and pcrmv_ram.
module pcrmv_back import pcrmv_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int MAX_SPECTRA = MAX_SPECTRA_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qstat i_qstat,
    input  t_cmd   i_cmd,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_res   o_res
);
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIV_STEPS = RECIP_W + 1;
    localparam int DCW = $clog2(DIV_STEPS + 1);

    t_bstate r_state, n_state;
    t_cmd    r_cmd;

    logic [RECIP_W-1:0]         r_recip;
    logic [RECIP_W:0]           r_dvd;
    logic [COUNT_W-1:0]         r_rem;
    logic [DCW-1:0]             r_dcnt;
    logic [MEAN_W-1:0]          r_d1, r_d2, r_nmean, r_mean_f;
    logic                       r_up, r_up2;
    logic [MEAN_W+RECIP_W-1:0]  r_prod1;
    logic [2*MEAN_W-1:0]        r_prod2;
    logic [SUM_W-1:0]           r_sum_f;
    logic [SUM_HALF+RECIP_W-1:0] r_vlo, r_vhi;
    logic                       r_out_valid;
    t_res                       r_res;

    logic              ram_re, ram_we, load_out;
    logic [AW-1:0]     addr;
    logic [MEAN_W-1:0] mean_rd, x_fx;
    logic [SUM_W-1:0]  sum_rd;
    logic [MEAN_W-1:0] upd_mean;
    logic [SUM_W-1:0]  upd_sum;

    assign addr = AW'(r_cmd.ch);
    assign x_fx = MEAN_W'(r_cmd.sample) << FRACTION_BITS;

    pcrmv_ram #(.WIDTH(MEAN_W), .DEPTH(CHANNELS)) u_mean_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(addr),
        .i_wdata(upd_mean),
        .i_re   (ram_re),
        .i_raddr(addr),
        .o_rdata(mean_rd)
    );

    pcrmv_ram #(.WIDTH(SUM_W), .DEPTH(CHANNELS)) u_sum_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(addr),
        .i_wdata(upd_sum),
        .i_re   (ram_re),
        .i_raddr(addr),
        .o_rdata(sum_rd)
    );

    // Sum update and final selection
    always_comb begin
        logic [2*MEAN_W:0] pr_full;
        logic [SUM_W-1:0]  pr;
        logic [SUM_W:0]    s_add;
        pr_full = {1'b0, r_prod2} + ((2*MEAN_W+1)'(1) << (FRACTION_BITS - 1));
        pr = SUM_W'(pr_full >> FRACTION_BITS);
        s_add = {1'b0, sum_rd} + {1'b0, pr};
        if (r_cmd.stopped) begin
            upd_mean = mean_rd;
            upd_sum = sum_rd;
        end else if (r_cmd.n <= COUNT_W'(1)) begin
            upd_mean = x_fx;
            upd_sum = '0;
        end else begin
            upd_mean = r_nmean;
            if (r_up == r_up2 || r_d1 == '0 || r_d2 == '0) begin
                upd_sum = s_add[SUM_W] ? '1 : s_add[SUM_W-1:0];
            end else begin
                upd_sum = (pr > sum_rd) ? '0 : sum_rd - pr;
            end
        end
    end

    // Control
    always_comb begin
        n_state = r_state;
        o_pop = 1'b0;
        ram_re = 1'b0;
        ram_we = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    n_state = (i_cmd.recalc && i_cmd.n > COUNT_W'(1)) ? ST_DIV : ST_READ;
                end
            end
            ST_DIV: begin
                if (r_dcnt == DCW'(DIV_STEPS)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                ram_re = 1'b1;
                n_state = ST_STEP;
            end
            ST_STEP: n_state = ST_MEAN;
            ST_MEAN: n_state = ST_DEV;
            ST_DEV:  n_state = ST_UPD;
            ST_UPD: begin
                ram_we = !r_cmd.stopped;
                n_state = ST_VLO;
            end
            ST_VLO:  n_state = ST_VHI;
            ST_VHI:  n_state = ST_OUT;
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        logic [MEAN_W-1:0]         d1, d2, nm;
        logic                      up2;
        logic [MEAN_W+RECIP_W:0]   st_full;
        logic [MEAN_W:0]           step, m_add;
        logic [COUNT_W:0]          trial;
        logic [SUM_HALF+RECIP_W+SUM_HALF:0] vt;
        logic [SUM_W-1:0]          v;
        if (!i_rst_n) begin
            r_recip <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_cmd <= i_cmd;
                    r_dvd <= (RECIP_W+1)'(1) << RECIP_W | (RECIP_W+1)'(i_cmd.n >> 1);
                    r_rem <= '0;
                    r_dcnt <= '0;
                    if (o_pop && i_cmd.recalc && i_cmd.n <= COUNT_W'(1)) begin
                        r_recip <= '1;
                    end
                end
                ST_DIV: begin
                    trial = {r_rem, r_dvd[RECIP_W]};
                    if (r_dcnt == DCW'(DIV_STEPS)) begin
                        r_recip <= r_dvd[RECIP_W-1:0];
                    end else if (trial >= {1'b0, r_cmd.n}) begin
                        r_rem <= COUNT_W'(trial - {1'b0, r_cmd.n});
                        r_dvd <= {r_dvd[RECIP_W-1:0], 1'b1};
                        r_dcnt <= r_dcnt + 1'b1;
                    end else begin
                        r_rem <= trial[COUNT_W-1:0];
                        r_dvd <= {r_dvd[RECIP_W-1:0], 1'b0};
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                ST_STEP: begin
                    r_up <= x_fx >= mean_rd;
                    d1 = (x_fx >= mean_rd) ? x_fx - mean_rd : mean_rd - x_fx;
                    r_d1 <= d1;
                    r_prod1 <= d1 * r_recip;
                end
                ST_MEAN: begin
                    st_full = {1'b0, r_prod1} + ((MEAN_W+RECIP_W+1)'(1) << (RECIP_W - 1));
                    step = (MEAN_W+1)'(st_full >> RECIP_W);
                    if (r_up) begin
                        m_add = {1'b0, mean_rd} + step;
                        nm = (m_add > {1'b0, MEAN_MAX}) ? MEAN_MAX : m_add[MEAN_W-1:0];
                    end else begin
                        nm = (step > {1'b0, mean_rd}) ? '0 : mean_rd - step[MEAN_W-1:0];
                    end
                    up2 = x_fx >= nm;
                    d2 = up2 ? x_fx - nm : nm - x_fx;
                    r_nmean <= nm;
                    r_up2 <= up2;
                    r_d2 <= d2;
                end
                ST_DEV: begin
                    r_prod2 <= r_d1 * r_d2;
                end
                ST_UPD: begin
                    r_mean_f <= upd_mean;
                    r_sum_f <= upd_sum;
                end
                ST_VLO: begin
                    r_vlo <= r_sum_f[SUM_HALF-1:0] * r_recip;
                end
                ST_VHI: begin
                    r_vhi <= r_sum_f[SUM_W-1:SUM_HALF] * r_recip;
                end
                ST_OUT: begin
                    vt = ({1'b0, r_vhi, {SUM_HALF{1'b0}}} + (SUM_W+RECIP_W+1)'(r_vlo))
                        + ((SUM_W+RECIP_W+1)'(1) << (RECIP_W - 1));
                    v = SUM_W'(vt >> RECIP_W);
                    if (load_out) begin
                        r_res.idx <= IDX_W'(r_cmd.ch);
                        r_res.mean <= r_mean_f;
                        if (r_cmd.n <= COUNT_W'(1)) begin
                            r_res.variance <= '0;
                        end else if (v > SUM_W'({VAR_W{1'b1}})) begin
                            r_res.variance <= '1;
                        end else begin
                            r_res.variance <= v[VAR_W-1:0];
                        end
                        r_res.count <= r_cmd.n;
                        r_res.sat <= 32'(r_cmd.n) >= MAX_SPECTRA;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res = r_res;
endmodule

// ----- hw/rtl/per_channel_running_mean_variance.sv -----
// Per-channel running mean and variance (Welford), top level.
// Depends on pcrmv_pkg, pcrmv_front, pcrmv_queue, pcrmv_back, assert_macros.svh.
//
// Samples arrive in channel order on the slave stream; tuser marks a block
// start. Every sample returns its channel's updated mean and population variance
// with 16 fraction bits. Each word passes through the back end in order: pop, RAM
// read, two update multiplies, write-back, two variance partial products, output
// register; a word that opens a spectrum after the first also runs the bit-serial
// reciprocal divider. A stalled receiver holds the back end in its output stage.
// No clearing pass: a channel's first-spectrum word writes its entry.
`include "assert_macros.svh"
module per_channel_running_mean_variance import pcrmv_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int MAX_SPECTRA = MAX_SPECTRA_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] sample_value
    input  logic                  s_tuser,   // [0] block_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [11:0] channel_index, [35:12] running_mean, [65:36] running_variance,
    // [81:66] spectra_count, [87:82] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser    // [0] count_saturated
);
    t_cmd   f_cmd, q_cmd;
    t_qstat q_st;
    t_res   res;
    logic   push, pop;

    pcrmv_front #(.CHANNELS(CHANNELS), .MAX_SPECTRA(MAX_SPECTRA)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid   (s_tvalid),
        .i_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .i_start   (s_tuser),
        .i_qstat   (q_st),
        .o_ready   (s_tready),
        .o_push    (push),
        .o_cmd     (f_cmd)
    );

    pcrmv_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (f_cmd),
        .i_pop  (pop),
        .o_cmd  (q_cmd),
        .o_qstat(q_st)
    );

    pcrmv_back #(.CHANNELS(CHANNELS), .MAX_SPECTRA(MAX_SPECTRA)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_qstat(q_st),
        .i_cmd  (q_cmd),
        .o_pop  (pop),
        .o_valid(m_tvalid),
        .i_ready(m_tready),
        .o_res  (res)
    );

    assign m_tdata = {6'd0, res.count, res.variance, res.mean, res.idx};
    assign m_tuser = res.sat;

    `PCRMV_ASSERT(a_q_state, i_clk, i_rst_n, $onehot0({q_st.full, q_st.empty}), "queue full and empty")
    `PCRMV_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, pop, !q_st.empty, "pop from empty queue")
    `PCRMV_ASSERT_IMPL(a_sat_flag, i_clk, i_rst_n, m_tvalid && m_tuser, 32'(m_tdata[81:66]) >= MAX_SPECTRA, "saturation flag without full count")
endmodule

// ----- tb/pcrmv_checker.sv -----
// Checker for per_channel_running_mean_variance: watches the config port and both
// streams, predicts each result word and compares it field by field.
// Depends on pcrmv_pkg.
module pcrmv_checker import pcrmv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked
);

    localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

    logic [CFG_W-1:0] chan_cfg;
    int               chan_pos;
    int               spectra;
    logic [31:0]      recip;
    logic             frozen;
    logic [63:0]      mean_mem [CHANNELS_DEF];
    logic [63:0]      dev_mem [CHANNELS_DEF];
    t_res             expected_words [$];

    assign o_pending = expected_words.size();

    function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (sh - 1));
        if ((p >> (sh + 64)) != 0)
            return '1;
        return 64'(p >> sh);
    endfunction

    task automatic update_channel(input logic [7:0] x, input logic blk_start);
        int          lim;
        int          ch;
        logic [63:0] xf, m, s, d1, d2, stp, nm, prod, v;
        logic        up, up2;
        t_res        r;
        lim = (chan_cfg == 0) ? 1 : (chan_cfg > CHANNELS_DEF) ? CHANNELS_DEF : int'(chan_cfg);
        if (blk_start) begin
            chan_pos = 0;
            spectra = 0;
            frozen = 1'b0;
        end
        if (chan_pos >= lim)
            chan_pos = 0;
        if (chan_pos == 0) begin
            if (spectra < MAX_SPECTRA_DEF) begin
                spectra++;
                recip = (spectra <= 1) ? 32'hFFFF_FFFF
                      : 32'(((64'd1 << 32) + 64'(spectra / 2)) / 64'(spectra));
            end else begin
                frozen = 1'b1;
            end
        end
        ch = chan_pos;
        m = mean_mem[ch];
        s = dev_mem[ch];
        xf = 64'(x) << FRACTION_BITS;
        if (!frozen) begin
            if (spectra <= 1) begin
                m = xf;
                s = 0;
            end else begin
                up = xf >= m;
                d1 = up ? xf - m : m - xf;
                stp = mul_round(d1, 64'(recip), 32);
                if (up)
                    nm = m + stp;
                else
                    nm = (stp > m) ? 64'd0 : m - stp;
                if (nm > 64'(MEAN_MAX))
                    nm = 64'(MEAN_MAX);
                up2 = xf >= nm;
                d2 = up2 ? xf - nm : nm - xf;
                prod = mul_round(d1, d2, FRACTION_BITS);
                if (up == up2 || d1 == 0 || d2 == 0)
                    s = (s > SUM_LIMIT - prod || prod > SUM_LIMIT) ? SUM_LIMIT : s + prod;
                else
                    s = (prod > s) ? 64'd0 : s - prod;
                m = nm;
            end
            mean_mem[ch] = m;
            dev_mem[ch] = s;
        end
        v = (spectra <= 1) ? 64'd0 : mul_round(s, 64'(recip), 32);
        if (v > 64'h3FFF_FFFF)
            v = 64'h3FFF_FFFF;
        r.idx = IDX_W'(ch);
        r.mean = MEAN_W'(m);
        r.variance = VAR_W'(v);
        r.count = COUNT_W'(spectra);
        r.sat = spectra >= MAX_SPECTRA_DEF;
        expected_words.push_back(r);
        chan_pos++;
        if (chan_pos >= lim)
            chan_pos = 0;
    endtask

    task automatic compare_word();
        t_res e;
        if (expected_words.size() == 0) begin
            $error("unexpected result word %h", m_tdata);
            o_errors++;
            return;
        end
        e = expected_words.pop_front();
        o_checked++;
        if (m_tdata[11:0] != e.idx) begin
            $error("channel_index exp %0d got %0d", e.idx, m_tdata[11:0]);
            o_errors++;
        end
        if (m_tdata[35:12] != e.mean) begin
            $error("running_mean exp %h got %h", e.mean, m_tdata[35:12]);
            o_errors++;
        end
        if (m_tdata[65:36] != e.variance) begin
            $error("running_variance exp %h got %h", e.variance, m_tdata[65:36]);
            o_errors++;
        end
        if (m_tdata[81:66] != e.count) begin
            $error("spectra_count exp %0d got %0d", e.count, m_tdata[81:66]);
            o_errors++;
        end
        if (m_tuser != e.sat) begin
            $error("count_saturated exp %0d got %0d", e.sat, m_tuser);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_checked = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chan_cfg = CFG_RESET;
            chan_pos = 0;
            spectra = 0;
            recip = 0;
            frozen = 1'b0;
            expected_words.delete();
        end else begin
            if (i_cfg_we)
                chan_cfg = i_cfg_data;
            if (s_tvalid && s_tready)
                update_channel(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                compare_word();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the per_channel_running_mean_variance testbench: clock, reset, stimulus
// phases over several channel counts and idle patterns, and the verdict.
// Depends on pcrmv_pkg, per_channel_running_mean_variance, pcrmv_checker.
module testbench import pcrmv_pkg::*;;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  s_tvalid, s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid, m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    int                    errors, pending, checked;

    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_req;
    int   hold_left;
    int   lim;
    int   pos;
    int   seen;
    bit   written [CHANNELS_DEF];
    int   cfg_writes;
    int   starts_sent;

    per_channel_running_mean_variance i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    pcrmv_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 2000000);
        $display("per_channel_running_mean_variance regression: fail");
        $finish;
    end

    // receiver: random stalls plus requested long hold-offs
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // sends one word; forces a block start where the word would read a channel
    // never written since reset
    task automatic send_word(input logic [7:0] x, input logic st);
        int p, s, gap;
        p = (pos >= lim) ? 0 : pos;
        s = (p == 0) ? seen + 1 : seen;
        if (!st && s >= 2 && !written[p])
            st = 1'b1;
        if (st) begin
            p = 0;
            s = 1;
            starts_sent++;
        end
        if (s == 1)
            written[p] = 1'b1;
        seen = s;
        pos = (p + 1 >= lim) ? 0 : p + 1;
        s_tvalid <= 1'b1;
        s_tdata <= x;
        s_tuser <= st;
        do @(posedge i_clk); while (!s_tready);
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_channels(input logic [CFG_W-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lim = (v == 0) ? 1 : (v > CHANNELS_DEF) ? CHANNELS_DEF : int'(v);
        cfg_writes++;
    endtask

    task automatic random_words(input int count);
        int k;
        logic [7:0] x;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0: x = 8'd0;
                1: x = 8'd255;
                default: x = 8'($urandom_range(255));
            endcase
            send_word(x, $urandom_range(99) < 2);
        end
    endtask

    logic [CFG_W-1:0] cfg_list [9] = '{13'd7, 13'd3, 13'd1, 13'd0, 13'd16,
                                       13'd8191, 13'd2, 13'd33, 13'd4096};
    int               item_list [9] = '{200, 200, 180, 120, 250, 60, 220, 300, 50};

    initial begin
        int ph, k;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        hold_left = 0;
        lim = CHANNELS_DEF;
        pos = 0;
        seen = 0;
        cfg_writes = 0;
        starts_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset channel count, first spectrum only
        for (k = 0; k < 12; k++)
            send_word(8'($urandom_range(255)), k == 0);

        // directed: two channels, extreme swings both ways, restarts
        write_channels(13'd2);
        send_word(8'd255, 1'b1);
        send_word(8'd0, 1'b0);
        send_word(8'd0, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd0, 1'b0);
        send_word(8'd0, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd128, 1'b0);
        send_word(8'd128, 1'b1);
        send_word(8'd1, 1'b0);
        send_word(8'd254, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'd255, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b0);

        // long receiver hold-off while the sender keeps offering words
        hold_req = 300;
        random_words(40);
        // sender pause until everything has come back
        drain();

        for (ph = 0; ph < 9; ph++) begin
            write_channels(cfg_list[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            random_words(item_list[ph]);
        end

        drain();
        $display("checked %0d result words over %0d channel settings, %0d block starts",
                 checked, cfg_writes, starts_sent);
        $display("idle patterns: none, sender gaps, receiver stalls, both; one long hold-off");
        if (errors == 0 && pending == 0)
            $display("per_channel_running_mean_variance regression: pass");
        else
            $display("per_channel_running_mean_variance regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pcrmv_pkg.sv
hw/rtl/pcrmv_ram.sv
hw/rtl/pcrmv_front.sv
hw/rtl/pcrmv_queue.sv
hw/rtl/pcrmv_back.sv
hw/rtl/per_channel_running_mean_variance.sv
tb/pcrmv_checker.sv
tb/testbench.sv
